// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Every check is sampled on aclk and is off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge after reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Implication of the form antecedent |-> or |=> consequent.
`define ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`endif

// File: hdl/wsca_pkg.sv
package wsca_pkg;

    // Sector codes and angle constants
    localparam logic [3:0]  SECTOR_UNDEF = 4'd8;
    localparam int unsigned STEP_DEG     = 45;
    localparam int unsigned FULL_DEG     = 360;

    // Config port
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned TABLE_W = 60;
    localparam logic        REG_SECTOR_TABLE = 1'b0;   // register index, paddr[3]

    // Status handed from a ring to the pipeline
    typedef struct packed {
        logic       wrap;   // this push completed a full pass of the ring
        logic [2:0] avg;    // average sector after this word
    } ring_stat_t;

    // Angle of a sector; undefined (8) gives 360
    function automatic logic [8:0] angle_of(input logic [3:0] s);
        return 9'(s) * 9'(STEP_DEG);
    endfunction

    // ((sum / depth) % 360) / 45 without a divider: sum never exceeds
    // 360 * depth, so the sector is a count of threshold crossings.
    function automatic logic [2:0] avg_sector(input logic [15:0] sum,
                                              input int unsigned depth);
        logic [2:0] a;
        a = '0;
        for (int k = 1; k < 8; k++) begin
            if (32'(sum) >= 32'(STEP_DEG * k * depth)) begin
                a = 3'(k);
            end
        end
        if (32'(sum) >= 32'(FULL_DEG * depth)) begin
            a = '0;
        end
        return a;
    endfunction

endpackage

// File: hdl/wsca_cell.sv
module wsca_cell
    import wsca_pkg::*;
#(
    parameter int unsigned SW = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [SW-1:0] d,
    output logic [SW-1:0] q
);

    logic [SW-1:0] cell_reg;

    // One ring entry; takes its neighbor's value on each push
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else if (en) begin
            cell_reg <= d;
        end
    end

    assign q = cell_reg;

endmodule

// File: hdl/wsca_ring.sv
module wsca_ring
    import wsca_pkg::*;
#(
    parameter int unsigned DEPTH = 10,
    parameter int unsigned SW    = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [SW-1:0] din,
    output ring_stat_t    stat
);

    `include "assert_macros.svh"

    localparam int unsigned CNT_W  = $clog2(DEPTH);
    localparam int unsigned SUM_W  = $clog2(FULL_DEG * DEPTH + 1);
    localparam int unsigned SUM_W1 = SUM_W + 1;

    logic [SW-1:0]    tap [DEPTH];
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_after;

    // Shift line of cells: oldest entry falls off the tail
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        wsca_cell #(.SW(SW)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (push),
            .d       ((i == 0) ? din : tap[(i == 0) ? 0 : i - 1]),
            .q       (tap[i])
        );
    end

    // Running angle sum: drop the tail, add the new word
    assign sum_next = SUM_W'(SUM_W1'(sum_reg) + SUM_W1'(angle_of(4'(din)))
                             - SUM_W1'(angle_of(4'(tap[DEPTH-1]))));
    assign sum_after = push ? sum_next : sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end else if (push) begin
            sum_reg <= sum_next;
            cnt_reg <= (cnt_reg == CNT_W'(DEPTH - 1)) ? '0 : cnt_reg + 1'b1;
        end
    end

    // Status for the word being pushed (or current state when idle)
    assign stat.wrap = push && (cnt_reg == CNT_W'(DEPTH - 1));
    assign stat.avg  = avg_sector(16'(sum_after), DEPTH);

    `ASSERT_IMPL(a_wrap_cnt, (push && stat.wrap) |=> (cnt_reg == '0),
        "ring count did not restart after wrap")
    `ASSERT_IMPL(a_sum_hold, !push |=> $stable(sum_reg),
        "ring sum changed without a push")
    `ASSERT_ALWAYS(a_sum_range, sum_reg <= SUM_W'(FULL_DEG * DEPTH),
        "ring sum above full-circle bound")

endmodule

// File: hdl/wind_sector_cascaded_average.sv
// Channel  | Ports                                    | Word
// ---------+------------------------------------------+------------------------------
// input    | s_valid, s_ready, s_adc_sample           | one vane ADC reading
// result   | m_valid, m_ready, m_sector_now,          | sector and three average
//          | m_angle_short, m_angle_mid, m_angle_long | angles, one per input word
// config   | psel, penable, pwrite, paddr, pwdata,    | sector table at address 0
//          | prdata, pready                           |
//
// One word per cycle sustained while m_ready stays high; a result is presented once its input word
// has passed through three stage registers, one for each ring's sum update and average.
// Reset (aresetn low, synchronous) zeroes all rings, sums, counts and the table.
// m_ready low holds the result; earlier stages keep accepting until all three
// stage registers are full, then s_ready drops.
module wind_sector_cascaded_average
    import wsca_pkg::*;
#(
    parameter int unsigned SHORT_DEPTH = 10,
    parameter int unsigned MID_DEPTH   = 6,
    parameter int unsigned LONG_DEPTH  = 60
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [11:0]       s_adc_sample,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [3:0]        m_sector_now,
    output logic [8:0]        m_angle_short,
    output logic [8:0]        m_angle_mid,
    output logic [8:0]        m_angle_long,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    `include "assert_macros.svh"

    logic [TABLE_W-1:0] table_reg;
    logic [63:0]        table_ext;
    logic [3:0]         code;
    logic [3:0]         sec_in;

    logic       v1_reg, v2_reg, vo_reg;
    logic       rdy1, rdy2, rdy_o;
    logic       ld1, ld2, ld3;

    logic [3:0] sec1_reg, sec2_reg, seco_reg;
    logic [2:0] savg1_reg, savg2_reg, savgo_reg;
    logic       swrap1_reg;
    logic [2:0] mavg2_reg, mavgo_reg;
    logic       mwrap2_reg;
    logic [2:0] lavgo_reg;

    ring_stat_t short_stat, mid_stat, long_stat;

    // Config register write and read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_reg <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[3] == REG_SECTOR_TABLE)) begin
            table_reg <= pwdata[TABLE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_SECTOR_TABLE) ? DATA_W'(table_reg) : '0;

    // Sector lookup: index fifteen lands on the padded undefined code
    assign table_ext = {SECTOR_UNDEF, table_reg};
    assign code      = table_ext[{s_adc_sample[11:8], 2'b00} +: 4];
    assign sec_in    = (code >= SECTOR_UNDEF) ? SECTOR_UNDEF : code;

    // Per-stage handshake
    assign rdy_o   = !vo_reg || m_ready;
    assign rdy2    = !v2_reg || rdy_o;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign ld1     = s_valid && rdy1;
    assign ld2     = v1_reg && rdy2;
    assign ld3     = v2_reg && rdy_o;

    // Cascade of rings, each pushed by its own stage
    wsca_ring #(.DEPTH(SHORT_DEPTH), .SW(4)) u_short (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (ld1),
        .din     (sec_in),
        .stat    (short_stat)
    );

    wsca_ring #(.DEPTH(MID_DEPTH), .SW(3)) u_mid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (ld2 && swrap1_reg),
        .din     (savg1_reg),
        .stat    (mid_stat)
    );

    wsca_ring #(.DEPTH(LONG_DEPTH), .SW(3)) u_long (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (ld3 && mwrap2_reg),
        .din     (mavg2_reg),
        .stat    (long_stat)
    );

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy_o) begin
                vo_reg <= v2_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (ld1) begin
            sec1_reg   <= sec_in;
            savg1_reg  <= short_stat.avg;
            swrap1_reg <= short_stat.wrap;
        end
        if (ld2) begin
            sec2_reg   <= sec1_reg;
            savg2_reg  <= savg1_reg;
            mavg2_reg  <= mid_stat.avg;
            mwrap2_reg <= mid_stat.wrap;
        end
        if (ld3) begin
            seco_reg  <= sec2_reg;
            savgo_reg <= savg2_reg;
            mavgo_reg <= mavg2_reg;
            lavgo_reg <= long_stat.avg;
        end
    end

    // Result word
    assign m_valid       = vo_reg;
    assign m_sector_now  = seco_reg;
    assign m_angle_short = angle_of({1'b0, savgo_reg});
    assign m_angle_mid   = angle_of({1'b0, mavgo_reg});
    assign m_angle_long  = angle_of({1'b0, lavgo_reg});

    `ASSERT_IMPL(a_empty_ready, !vo_reg |-> s_ready,
        "input stalled with an empty output stage")
    `ASSERT_IMPL(a_mid_fill, ld2 |=> v2_reg,
        "word lost between first and second stage")
    `ASSERT_IMPL(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_sector_now)),
        "result word changed while stalled")

endmodule
